// ===== design/dst_pkg.sv =====
// Package for the device sighting table: sizes, codes and transaction types.
// No dependencies; every other file in the design imports it.
package dst_pkg;
  localparam int DEVICE_SLOTS  = 32;
  localparam int HISTORY_DEPTH = 20;
  localparam int SLOT_W = (DEVICE_SLOTS > 1) ? $clog2(DEVICE_SLOTS) : 1;
  localparam int HIST_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam int MEM_DEPTH = DEVICE_SLOTS * HISTORY_DEPTH;
  localparam int MEM_W = $clog2(MEM_DEPTH);

  localparam logic [1:0] FUNC_SIGHT = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic [47:0]        address;
    logic signed [7:0]  sighting_rssi;
  } in_item_t;

  typedef struct packed {
    logic               is_new;
    logic               entry_found;
    logic               dropped_full;
    logic [5:0]         device_count;
    logic signed [7:0]  best_rssi;
    logic signed [7:0]  worst_rssi;
    logic signed [39:0] strength_sum;
    logic [31:0]        sample_count;
    logic signed [7:0]  history_rssi;
    logic               last;
  } out_item_t;

  // Search token travelling down the chain of slot cells.
  typedef struct packed {
    logic [47:0]       address;
    logic              found;
    logic [SLOT_W-1:0] hit_slot;
    logic [FILL_W-1:0] hit_fill;
    logic [HIST_W-1:0] hit_head;
    logic              free_seen;
    logic [SLOT_W-1:0] free_slot;
  } search_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic              clear;
    logic              insert;
    logic              append;
    logic [SLOT_W-1:0] slot;
    logic [47:0]       address;
  } cell_cmd_t;
endpackage

// ===== design/dst_cell.sv =====
// One slot of the table: address, valid, history fill and head.
// Depends on dst_pkg; passes the registered search token to its neighbour.
module dst_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [dst_pkg::SLOT_W-1:0] my_slot,
  input  dst_pkg::search_t  tok_in,
  input  dst_pkg::cell_cmd_t cmd,
  output dst_pkg::search_t  tok_out
);
  import dst_pkg::*;
  logic [47:0]       addr_r;
  logic              valid_r;
  logic [FILL_W-1:0] fill_r;
  logic [HIST_W-1:0] head_r;
  search_t           tok_r, tok_nxt;
  logic              sel;

  assign sel = cmd.slot == my_slot;

  always_comb begin
    tok_nxt = tok_in;
    if (valid_r && addr_r == tok_in.address && !tok_in.found) begin
      tok_nxt.found    = 1'b1;
      tok_nxt.hit_slot = my_slot;
      tok_nxt.hit_fill = fill_r;
      tok_nxt.hit_head = head_r;
    end
    if (!valid_r && !tok_in.free_seen) begin
      tok_nxt.free_seen = 1'b1;
      tok_nxt.free_slot = my_slot;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
    if (!rst_n || cmd.clear) begin
      valid_r <= 1'b0;
      fill_r  <= '0;
      head_r  <= '0;
    end else if (sel && cmd.insert) begin
      valid_r <= 1'b1;
      addr_r  <= cmd.address;
      fill_r  <= FILL_W'(1);
      head_r  <= '0;
    end else if (sel && cmd.append) begin
      if (fill_r < FILL_W'(HISTORY_DEPTH)) fill_r <= fill_r + 1'b1;
      else if (head_r == HIST_W'(HISTORY_DEPTH - 1)) head_r <= '0;
      else head_r <= head_r + 1'b1;
    end
  end

  assign tok_out = tok_r;
endmodule

// ===== design/dst_hist_ram.sv =====
// History sample memory, one row of samples per slot, registered read.
// Depends on dst_pkg for its size.
module dst_hist_ram (
  input  logic                     clk,
  input  logic                     we,
  input  logic [dst_pkg::MEM_W-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic [dst_pkg::MEM_W-1:0] raddr,
  output logic [7:0]               rdata
);
  import dst_pkg::*;
  logic [7:0] mem [MEM_DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== design/device_sighting_table.sv =====
// Top level of the device sighting table: controller, slot chain, statistics.
// Depends on dst_pkg, dst_cell and dst_hist_ram.
//
//   channel | ports              | payload
//   input   | in_valid/in_ready  | in_item_t (func, address, sighting_rssi)
//   result  | out_valid/out_ready| out_item_t
//
// A transaction's search token passes through the chain of DEVICE_SLOTS
// registered cells before the decide state acts on it, and a read then
// delivers each sample through a read state and an emit state from the registered history memory.
// A clear is answered from the idle state. Reset is synchronous and needs no clearing pass.
// A stalled result holds in the output register; new input and further results wait for it.
module device_sighting_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dst_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dst_pkg::out_item_t out_data
);
  import dst_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SEARCH, S_DECIDE, S_READ, S_EMIT} state_t;
  state_t state_r;

  search_t           chain [DEVICE_SLOTS+1];
  cell_cmd_t         cmd;
  in_item_t          item_r;
  logic [SLOT_W:0]   cnt_r;
  search_t           res_r;
  logic [FILL_W-1:0] rd_k_r;
  logic [HIST_W-1:0] rd_pos_r;
  logic [5:0]        devs_r;
  logic [31:0]       samples_r;
  logic signed [39:0] sum_r;
  logic signed [7:0] best_r, worst_r;
  logic              out_valid_r;
  out_item_t         out_r;
  logic              we;
  logic [MEM_W-1:0]  waddr, raddr;
  logic [7:0]        rdata;
  logic signed [7:0] r_sat;
  logic signed [40:0] sum_ext;
  logic signed [39:0] sum_sat;
  logic [31:0]       samples_inc;
  logic [HIST_W-1:0] wpos;
  logic [HIST_W:0]   wpos_sum;

  assign chain[0] = '{address: item_r.address, default: '0};

  for (genvar g = 0; g < DEVICE_SLOTS; g++) begin : g_cell
    dst_cell u_cell (
      .clk(clk), .rst_n(rst_n), .my_slot(SLOT_W'(g)),
      .tok_in(chain[g]), .cmd(cmd), .tok_out(chain[g+1])
    );
  end

  assign r_sat   = item_r.sighting_rssi[7] ? item_r.sighting_rssi : 8'sd0;
  assign sum_ext = 41'(sum_r) + 41'(r_sat);
  assign sum_sat = (sum_ext < -41'sd549755813888) ? -40'sd549755813888 : 40'(sum_ext);
  assign samples_inc = (samples_r != 32'hFFFF_FFFF) ? samples_r + 1'b1 : samples_r;
  assign wpos_sum = (HIST_W+1)'(res_r.hit_head) + (HIST_W+1)'(res_r.hit_fill);

  always_comb begin
    if (!res_r.found) wpos = '0;
    else if (res_r.hit_fill < FILL_W'(HISTORY_DEPTH))
      wpos = (wpos_sum >= (HIST_W+1)'(HISTORY_DEPTH))
             ? HIST_W'(wpos_sum - (HIST_W+1)'(HISTORY_DEPTH)) : HIST_W'(wpos_sum);
    else wpos = res_r.hit_head;
  end

  always_comb begin
    cmd = '0;
    cmd.address = item_r.address;
    cmd.slot    = res_r.found ? res_r.hit_slot : res_r.free_slot;
    cmd.clear   = state_r == S_IDLE && in_valid && in_ready &&
                  in_data.func == FUNC_CLEAR;
    if (state_r == S_DECIDE && item_r.func == FUNC_SIGHT && !out_valid_r) begin
      cmd.append = res_r.found;
      cmd.insert = !res_r.found && res_r.free_seen;
    end
  end

  assign we    = cmd.append || cmd.insert;
  assign waddr = MEM_W'(cmd.slot * HISTORY_DEPTH + wpos);
  assign raddr = MEM_W'(res_r.hit_slot * HISTORY_DEPTH + rd_pos_r);

  dst_hist_ram u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(r_sat), .raddr(raddr), .rdata(rdata)
  );

  assign in_ready = state_r == S_IDLE && !out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      devs_r <= '0; samples_r <= '0; sum_r <= '0; best_r <= '0; worst_r <= '0;
    end else begin
      // The emit state reloads the output register itself.
      if (out_valid_r && out_ready && state_r != S_EMIT) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_valid && in_ready) begin
          item_r <= in_data;
          cnt_r  <= '0;
          if (in_data.func == FUNC_CLEAR) begin
            devs_r <= '0;
            out_valid_r <= 1'b1;
            out_r <= '{device_count: 6'd0, best_rssi: best_r, worst_rssi: worst_r,
                       strength_sum: sum_r, sample_count: samples_r,
                       last: 1'b1, default: '0};
          end else if (in_data.func == FUNC_SIGHT || in_data.func == FUNC_READ)
            state_r <= S_SEARCH;
        end
        S_SEARCH: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == (SLOT_W+1)'(DEVICE_SLOTS)) begin
            res_r <= chain[DEVICE_SLOTS];
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: if (!out_valid_r) begin
          if (item_r.func == FUNC_SIGHT) begin
            logic signed [7:0] b, w;
            logic [5:0] d;
            b = (samples_r == 0 || r_sat > best_r) ? r_sat : best_r;
            w = (samples_r == 0 || r_sat < worst_r) ? r_sat : worst_r;
            d = (!res_r.found && res_r.free_seen) ? devs_r + 1'b1 : devs_r;
            best_r <= b; worst_r <= w; devs_r <= d;
            sum_r <= sum_sat;
            samples_r <= samples_inc;
            out_r <= '{is_new: !res_r.found && res_r.free_seen,
                       entry_found: res_r.found,
                       dropped_full: !res_r.found && !res_r.free_seen,
                       device_count: d, best_rssi: b, worst_rssi: w,
                       strength_sum: sum_sat, sample_count: samples_inc,
                       last: 1'b1, default: '0};
            out_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end else if (!res_r.found || res_r.hit_fill == 0) begin
            out_r <= '{device_count: devs_r, best_rssi: best_r, worst_rssi: worst_r,
                       strength_sum: sum_r, sample_count: samples_r,
                       last: 1'b1, default: '0};
            out_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            rd_k_r <= '0;
            rd_pos_r <= res_r.hit_head;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          // Wait state for the registered memory read at rd_pos_r.
          state_r <= S_EMIT;
        end
        S_EMIT: if (!out_valid_r || out_ready) begin
          out_valid_r <= 1'b1;
          out_r <= '{entry_found: 1'b1, device_count: devs_r, best_rssi: best_r,
                     worst_rssi: worst_r, strength_sum: sum_r,
                     sample_count: samples_r, history_rssi: rdata,
                     last: (rd_k_r + 1'b1) == res_r.hit_fill, default: '0};
          if ((rd_k_r + 1'b1) == res_r.hit_fill) state_r <= S_IDLE;
          else begin
            rd_k_r <= rd_k_r + 1'b1;
            rd_pos_r <= (rd_pos_r == HIST_W'(HISTORY_DEPTH - 1)) ? '0
                                                                 : rd_pos_r + 1'b1;
            state_r <= S_READ;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule

// ===== design/dst_checker.sv =====
// Port-level checks for the device sighting table, bound to the top level.
// Depends on dst_pkg and device_sighting_table.
module dst_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input dst_pkg::out_item_t out_data
);
  import dst_pkg::*;
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken with result pending");
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({out_data.is_new, out_data.entry_found,
                              out_data.dropped_full}) <= 1)
    else $error("conflicting result flags");
  a_hist_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.entry_found |-> out_data.history_rssi == 0 && out_data.last)
    else $error("bad result without entry");
endmodule

bind device_sighting_table dst_checker u_dst_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

// ===== dv/device_sighting_table_tb.sv =====
// Self-checking testbench for device_sighting_table: directed and random sightings,
// history reads and clears, with a predictor of the table and its statistics.
// Depends on dst_pkg and the design files only.
module device_sighting_table_tb;
  import dst_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int POOL_SIZE = 40;

  typedef struct {
    in_item_t item;
    bit       wait_drain;
  } pending_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  device_sighting_table dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Predicted contents of the table.
  logic [47:0]       tbl_addr [DEVICE_SLOTS];
  bit                tbl_used [DEVICE_SLOTS];
  logic signed [7:0] tbl_hist [DEVICE_SLOTS][HISTORY_DEPTH];
  int                tbl_fill [DEVICE_SLOTS];
  int                tbl_head [DEVICE_SLOTS];
  logic [5:0]         dev_count;
  logic [31:0]        samples;
  logic signed [39:0] rssi_sum;
  logic signed [7:0]  rssi_best;
  logic signed [7:0]  rssi_worst;

  pending_t  pending_items [$];
  out_item_t expected_results [$];
  logic [47:0] addr_pool [POOL_SIZE];

  int errors = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_sightings = 0;
  int n_reads = 0;
  int n_clears = 0;
  int n_drops = 0;
  int n_full_hist = 0;

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  function automatic out_item_t status_word(bit nw, bit fnd, bit drp,
                                            logic signed [7:0] h, bit lst);
    out_item_t o;
    o.is_new       = nw;
    o.entry_found  = fnd;
    o.dropped_full = drp;
    o.device_count = dev_count;
    o.best_rssi    = rssi_best;
    o.worst_rssi   = rssi_worst;
    o.strength_sum = rssi_sum;
    o.sample_count = samples;
    o.history_rssi = h;
    o.last         = lst;
    return o;
  endfunction

  function automatic void push_sample(int s, logic signed [7:0] r);
    if (tbl_fill[s] < HISTORY_DEPTH) begin
      tbl_hist[s][(tbl_head[s] + tbl_fill[s]) % HISTORY_DEPTH] = r;
      tbl_fill[s]++;
    end else begin
      tbl_hist[s][tbl_head[s]] = r;
      tbl_head[s] = (tbl_head[s] + 1) % HISTORY_DEPTH;
      n_full_hist++;
    end
  endfunction

  // Updates the table for one accepted transaction and queues what it should return.
  function automatic void predict_table(in_item_t it);
    logic signed [7:0]  r;
    logic signed [40:0] acc;
    bit first;
    int hit;
    int free_slot;
    hit = -1;
    free_slot = -1;
    for (int i = 0; i < DEVICE_SLOTS; i++) begin
      if (tbl_used[i] && tbl_addr[i] == it.address && hit < 0) hit = i;
      if (!tbl_used[i] && free_slot < 0) free_slot = i;
    end
    case (it.func)
      FUNC_SIGHT: begin
        n_sightings++;
        r = (it.sighting_rssi > 0) ? 8'sd0 : it.sighting_rssi;
        first = (samples == 0);
        acc = 41'(rssi_sum) + 41'(r);
        rssi_sum = (acc < -(41'sd1 <<< 39)) ? -(40'sd1 <<< 39) : acc[39:0];
        if (samples != 32'hFFFF_FFFF) samples++;
        if (first || r > rssi_best) rssi_best = r;
        if (first || r < rssi_worst) rssi_worst = r;
        if (hit >= 0) begin
          push_sample(hit, r);
          expected_results.push_back(status_word(0, 1, 0, 0, 1));
        end else if (free_slot < 0) begin
          n_drops++;
          expected_results.push_back(status_word(0, 0, 1, 0, 1));
        end else begin
          tbl_used[free_slot] = 1;
          tbl_addr[free_slot] = it.address;
          tbl_fill[free_slot] = 0;
          tbl_head[free_slot] = 0;
          dev_count++;
          push_sample(free_slot, r);
          expected_results.push_back(status_word(1, 0, 0, 0, 1));
        end
      end
      FUNC_READ: begin
        n_reads++;
        if (hit < 0 || tbl_fill[hit] == 0) begin
          expected_results.push_back(status_word(0, 0, 0, 0, 1));
        end else begin
          for (int k = 0; k < tbl_fill[hit]; k++)
            expected_results.push_back(status_word(0, 1, 0,
              tbl_hist[hit][(tbl_head[hit] + k) % HISTORY_DEPTH], k + 1 == tbl_fill[hit]));
        end
      end
      FUNC_CLEAR: begin
        n_clears++;
        for (int i = 0; i < DEVICE_SLOTS; i++) begin
          tbl_used[i] = 0;
          tbl_fill[i] = 0;
          tbl_head[i] = 0;
        end
        dev_count = 0;
        expected_results.push_back(status_word(0, 0, 0, 0, 1));
      end
      default: ;
    endcase
  endfunction

  function automatic int idle_length();
    int p;
    // Every third stretch of sixty transactions runs with no idling at all.
    if ((n_accepted / 60) % 3 == 1) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void check_field(string name, logic [63:0] exp, logic [63:0] got);
    if (exp !== got) begin
      errors++;
      $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, exp, got);
    end
  endfunction

  // Driver.
  int send_gap;
  always @(posedge clk) begin
    pending_t p;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_table(in_data);
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0 &&
                     !(pending_items[0].wait_drain && expected_results.size() > 0)) begin
          p = pending_items.pop_front();
          in_data  <= p.item;
          in_valid <= 1'b1;
          send_gap = idle_length();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and result-side back-pressure.
  int  recv_stall;
  bit  long_hold_done;
  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_stall = 0;
      long_hold_done = 0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, actual %0h", $time, out_data);
        end else begin
          e = expected_results.pop_front();
          check_field("is_new",       e.is_new,       out_data.is_new);
          check_field("entry_found",  e.entry_found,  out_data.entry_found);
          check_field("dropped_full", e.dropped_full, out_data.dropped_full);
          check_field("device_count", e.device_count, out_data.device_count);
          check_field("best_rssi",    e.best_rssi,    out_data.best_rssi);
          check_field("worst_rssi",   e.worst_rssi,   out_data.worst_rssi);
          check_field("strength_sum", e.strength_sum, out_data.strength_sum);
          check_field("sample_count", e.sample_count, out_data.sample_count);
          check_field("history_rssi", e.history_rssi, out_data.history_rssi);
          check_field("last",         e.last,         out_data.last);
        end
      end
      // One long hold-off lets the block back up and stall its input.
      if (!long_hold_done && n_accepted >= 120) begin
        long_hold_done = 1;
        recv_stall = 400;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        recv_stall = idle_length();
      end
    end
  end

  function automatic logic [47:0] any_address();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic void queue_item(logic [1:0] f, logic [47:0] a,
                                     logic signed [7:0] r, bit drain = 0);
    pending_t p;
    p.item.func          = f;
    p.item.address       = a;
    p.item.sighting_rssi = r;
    p.wait_drain         = drain;
    pending_items.push_back(p);
  endfunction

  initial begin
    logic [47:0] a;
    int sel;
    rst_n = 1'b0;
    for (int i = 0; i < DEVICE_SLOTS; i++) begin
      tbl_used[i] = 0;
      tbl_fill[i] = 0;
      tbl_head[i] = 0;
    end
    dev_count = 0;
    samples = 0;
    rssi_sum = 0;
    rssi_best = 0;
    rssi_worst = 0;
    for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = any_address();

    // Directed part: address extremes, strength extremes, every operation.
    queue_item(FUNC_READ,   48'h0, 8'sd0);
    queue_item(FUNC_SIGHT,  48'h0, -8'sd128);
    queue_item(FUNC_SIGHT,  48'hFFFF_FFFF_FFFF, 8'sd0);
    queue_item(FUNC_SIGHT,  48'h0, 8'sd127);
    queue_item(FUNC_SIGHT,  48'hFFFF_FFFF_FFFF, -8'sd1);
    queue_item(FUNC_SIGHT,  48'hAAAA_AAAA_AAAA, -8'sd60);
    queue_item(FUNC_READ,   48'h0, 8'sd0);
    queue_item(FUNC_READ,   48'h5555_5555_5555, -8'sd1);
    queue_item(FUNC_UNUSED, 48'h0, -8'sd1);
    queue_item(FUNC_READ,   48'hFFFF_FFFF_FFFF, 8'sd0);
    queue_item(FUNC_CLEAR,  48'h0, 8'sd0);
    queue_item(FUNC_READ,   48'h0, 8'sd0);
    queue_item(FUNC_SIGHT,  48'h0, -8'sd5);

    // Random part, with periodic bursts that overflow one device's history.
    for (int n = 0; n < 380; n++) begin
      if (n % 150 == 75) begin
        a = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        for (int k = 0; k < HISTORY_DEPTH + 3; k++)
          queue_item(FUNC_SIGHT, a, -8'($urandom_range(0, 128)));
        queue_item(FUNC_READ, a, 8'($urandom));
      end
      sel = $urandom_range(0, 99);
      if (sel < 30) a = addr_pool[$urandom_range(0, 1)];
      else if (sel < 85) a = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
      else a = any_address();
      sel = $urandom_range(0, 99);
      if (sel < 68)
        queue_item(FUNC_SIGHT, a, (sel < 8) ? 8'($urandom) : -8'($urandom_range(0, 128)),
                   n == 250);
      else if (sel < 95) queue_item(FUNC_READ, a, 8'($urandom), n == 250);
      else if (sel < 97) queue_item(FUNC_CLEAR, a, 8'($urandom), n == 250);
      else queue_item(FUNC_UNUSED, a, 8'($urandom), n == 250);
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (120) @(posedge clk);

    $display("Covered %0d transactions: %0d sightings, %0d history reads, %0d clears.",
             n_accepted, n_sightings, n_reads, n_clears);
    $display("Checked %0d results; %0d table-full drops, %0d history overwrites.",
             n_results, n_drops, n_full_hist);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Regression FAIL");
    $finish;
  end
endmodule

// ===== sim.f =====
design/dst_pkg.sv
design/dst_cell.sv
design/dst_hist_ram.sv
design/device_sighting_table.sv
design/dst_checker.sv
dv/device_sighting_table_tb.sv
